// ----- rtl/core/ppb_pkg.sv -----
// Shared types, constants and helpers for the premultiplied pixel blend.
// No dependencies. Used by ppb_keep, ppb_lane and premultiplied_pixel_blend.
`timescale 1ns / 1ps
`default_nettype none

package ppb_pkg;

    localparam int NUM_LANES  = 4;   // r, g, b, a
    localparam int CHAN_W     = 8;
    localparam int WIDE_W     = 16;
    localparam int ACC_W      = 32;
    localparam int NUM_STAGES = 4;   // register stages ahead of the merge register
    localparam int ALPHA_LANE = 3;

    localparam logic MODE_SINGLE = 1'b0;
    localparam logic MODE_DOUBLE = 1'b1;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [WIDE_W-1:0] wide_t;
    typedef logic [ACC_W-1:0]  acc_t;

    // per-stage load enables, shared by every lane and the keep unit
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } ppb_ctrl_t;

    // v * 257
    function automatic wide_t widen8(input chan_t v);
        return {v, v};
    endfunction

    function automatic acc_t mul_wide(input wide_t a, input wide_t b);
        return ACC_W'(a) * ACC_W'(b);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/premultiplied_pixel_blend.sv -----
// Top level: premultiplied-alpha over blend, four channel lanes plus keep unit,
// merged into one output register. Depends on ppb_pkg, ppb_keep, ppb_lane.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, cmd, dst_pixel,        | to block
//          | first_colour, second_colour, first_alpha,  |
//          | second_alpha                               |
//  out     | out_valid, out_stall, blended_pixel        | from block
//
// One item per cycle while out_stall is low; five register stages, and out_valid is
// the valid bit of the last of them.
// Depth is set by the two dependent multiplies per lane (dst * k1, then mid * k2),
// each followed by a register, with the wrapping adds in their own stages.
// rst_n clears only the stage valid bits; payload registers are not reset.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up under out_stall and in_stall rises only when all five stages hold items.
`timescale 1ns / 1ps
`default_nettype none

module premultiplied_pixel_blend
    import ppb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [31:0] dst_pixel,
    input  wire logic [31:0] first_colour,
    input  wire logic [31:0] second_colour,
    input  wire logic [7:0]  first_alpha,
    input  wire logic [7:0]  second_alpha,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      blended_pixel
);

    localparam int ALL_STAGES = NUM_STAGES + 1;

    logic [ALL_STAGES-1:0] valid_reg;
    logic [ALL_STAGES-1:0] valid_next;
    logic [ALL_STAGES-1:0] load;
    logic [ALL_STAGES-1:0] upstream_valid;
    ppb_ctrl_t             ctrl;
    wide_t                 first_keep;
    wide_t                 second_keep;
    wide_t                 first_cov16;
    wide_t                 second_cov16;
    logic [NUM_LANES*CHAN_W-1:0] merged_next;
    logic [NUM_LANES*CHAN_W-1:0] blended_pixel_reg;

    assign upstream_valid = {valid_reg[ALL_STAGES-2:0], in_valid};

    always_comb
    begin
        load[ALL_STAGES-1] = !valid_reg[ALL_STAGES-1] || !out_stall;
        for (int i = ALL_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        for (int i = 0; i < ALL_STAGES; i++)
        begin
            valid_next[i] = load[i] ? upstream_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.en      = load[NUM_STAGES-1:0];
    assign in_stall     = !load[0];
    assign first_cov16  = widen8(first_alpha);
    assign second_cov16 = widen8(second_alpha);

    ppb_keep u_keep (
        .clk              (clk),
        .ctrl             (ctrl),
        .first_src_alpha  (first_colour[ALPHA_LANE*CHAN_W +: CHAN_W]),
        .first_cov        (first_alpha),
        .second_src_alpha (second_colour[ALPHA_LANE*CHAN_W +: CHAN_W]),
        .second_cov       (second_alpha),
        .first_keep       (first_keep),
        .second_keep      (second_keep)
    );

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        ppb_lane u_lane (
            .clk          (clk),
            .ctrl         (ctrl),
            .mode         (cmd),
            .dst_chan     (dst_pixel[g*CHAN_W +: CHAN_W]),
            .first_chan   (first_colour[g*CHAN_W +: CHAN_W]),
            .second_chan  (second_colour[g*CHAN_W +: CHAN_W]),
            .first_cov16  (first_cov16),
            .second_cov16 (second_cov16),
            .first_keep   (first_keep),
            .second_keep  (second_keep),
            .lane_out     (merged_next[g*CHAN_W +: CHAN_W])
        );
    end

    // merge stage: lane bytes packed into the output register
    always_ff @(posedge clk)
    begin
        if (load[ALL_STAGES-1])
        begin
            blended_pixel_reg <= merged_next;
        end
    end

    assign out_valid     = valid_reg[ALL_STAGES-1];
    assign blended_pixel = blended_pixel_reg;

    // backpressure only ever comes from a stalled, valid output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled output item");

    // a full pipe facing a stall must refuse new items
    assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && out_stall) |-> in_stall)
        else $error("full pipe accepted an item under stall");

    // an accepted item always lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted item lost at stage one");

    // a taken result is replaced only by what stood in the stage before it
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (out_valid == $past(valid_reg[ALL_STAGES-2])))
        else $error("output valid does not follow previous stage");

endmodule

`default_nettype wire

// ----- rtl/core/ppb_keep.sv -----
// Keep-factor unit: k = ~(src_a16 * cov16) >> 16 for both blend stages.
// Depends on ppb_pkg. k1 is ready for lane stage 2, k2 for lane stage 4.
`timescale 1ns / 1ps
`default_nettype none

module ppb_keep
    import ppb_pkg::*;
(
    input  wire logic      clk,
    input  wire ppb_ctrl_t ctrl,
    input  wire chan_t     first_src_alpha,
    input  wire chan_t     first_cov,
    input  wire chan_t     second_src_alpha,
    input  wire chan_t     second_cov,
    output wide_t          first_keep,
    output wide_t          second_keep
);

    acc_t  p1_reg;
    acc_t  p2_reg;
    wide_t k2_s2_reg;
    wide_t k2_s3_reg;
    acc_t  p1_next;
    acc_t  p2_next;
    wide_t k2_s2_next;

    // product never exceeds 32 bits, so (0xFFFFFFFF - p) >> 16 is ~p[31:16]
    assign p1_next    = mul_wide(widen8(first_src_alpha), widen8(first_cov));
    assign p2_next    = mul_wide(widen8(second_src_alpha), widen8(second_cov));
    assign k2_s2_next = ~p2_reg[ACC_W-1 -: WIDE_W];

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (ctrl.en[1])
        begin
            k2_s2_reg <= k2_s2_next;
        end
        if (ctrl.en[2])
        begin
            k2_s3_reg <= k2_s2_reg;
        end
    end

    assign first_keep  = ~p1_reg[ACC_W-1 -: WIDE_W];
    assign second_keep = k2_s3_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ppb_lane.sv -----
// One channel lane: two chained blend stages with registered multiplies.
// Depends on ppb_pkg; keep factors come from ppb_keep.
`timescale 1ns / 1ps
`default_nettype none

module ppb_lane
    import ppb_pkg::*;
(
    input  wire logic      clk,
    input  wire ppb_ctrl_t ctrl,
    input  wire logic      mode,
    input  wire chan_t     dst_chan,
    input  wire chan_t     first_chan,
    input  wire chan_t     second_chan,
    input  wire wide_t     first_cov16,
    input  wire wide_t     second_cov16,
    input  wire wide_t     first_keep,
    input  wire wide_t     second_keep,
    output chan_t          lane_out
);

    logic  mode_s1_reg, mode_s2_reg, mode_s3_reg, mode_s4_reg;
    wide_t d_s1_reg;
    acc_t  cp1_s1_reg, cp1_s2_reg;
    acc_t  cp2_s1_reg, cp2_s2_reg, cp2_s3_reg, cp2_s4_reg;
    acc_t  dk1_s2_reg;
    wide_t mid_s3_reg;
    chan_t single_s3_reg, single_s4_reg;
    acc_t  mk_s4_reg;

    acc_t  cp1_s1_next, cp2_s1_next, dk1_s2_next, sum1_next, mk_s4_next, sum2;

    assign cp1_s1_next = mul_wide(widen8(first_chan), first_cov16);
    assign cp2_s1_next = mul_wide(widen8(second_chan), second_cov16);
    assign dk1_s2_next = mul_wide(d_s1_reg, first_keep);
    assign sum1_next   = cp1_s2_reg + dk1_s2_reg;   // wraps mod 2^32
    assign mk_s4_next  = mul_wide(mid_s3_reg, second_keep);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            mode_s1_reg <= mode;
            d_s1_reg    <= widen8(dst_chan);
            cp1_s1_reg  <= cp1_s1_next;
            cp2_s1_reg  <= cp2_s1_next;
        end
        if (ctrl.en[1])
        begin
            mode_s2_reg <= mode_s1_reg;
            dk1_s2_reg  <= dk1_s2_next;
            cp1_s2_reg  <= cp1_s1_reg;
            cp2_s2_reg  <= cp2_s1_reg;
        end
        if (ctrl.en[2])
        begin
            mode_s3_reg   <= mode_s2_reg;
            mid_s3_reg    <= sum1_next[ACC_W-1 -: WIDE_W];
            single_s3_reg <= sum1_next[ACC_W-1 -: CHAN_W];
            cp2_s3_reg    <= cp2_s2_reg;
        end
        if (ctrl.en[3])
        begin
            mode_s4_reg   <= mode_s3_reg;
            single_s4_reg <= single_s3_reg;
            cp2_s4_reg    <= cp2_s3_reg;
            mk_s4_reg     <= mk_s4_next;
        end
    end

    assign sum2     = cp2_s4_reg + mk_s4_reg;
    assign lane_out = (mode_s4_reg == MODE_DOUBLE) ? sum2[ACC_W-1 -: CHAN_W] : single_s4_reg;

endmodule

`default_nettype wire
